// ===== sv/lsra_pkg.sv =====
// Shared constants for the linear scan register allocator.
package lsra_pkg;

	// Field widths of the item and result words.
	localparam int CFG_W   = 6;
	localparam int ID_W    = 16;
	localparam int POINT_W = 32;
	localparam int REG_W   = 5;

	// Register count after reset.
	localparam logic [CFG_W-1:0] NUM_REGS_RESET = 6'd16;

endpackage

// ===== sv/lsra_channels.sv =====
// Valid/ready channel interfaces for interval words and allocation result words.
interface lsra_item_if;
	logic                         valid;
	logic                         ready;
	logic                         start_function;
	logic [lsra_pkg::ID_W-1:0]    vreg_id;
	logic [lsra_pkg::POINT_W-1:0] def_point;
	logic [lsra_pkg::POINT_W-1:0] end_point;

	modport source (output valid, start_function, vreg_id, def_point, end_point, input ready);
	modport sink (input valid, start_function, vreg_id, def_point, end_point, output ready);
endinterface

interface lsra_result_if;
	logic                       valid;
	logic                       ready;
	logic [lsra_pkg::REG_W-1:0] assigned_reg;
	logic                       is_spilled;
	logic                       evicted;
	logic [lsra_pkg::ID_W-1:0]  evicted_id;

	modport source (output valid, assigned_reg, is_spilled, evicted, evicted_id, input ready);
	modport sink (input valid, assigned_reg, is_spilled, evicted, evicted_id, output ready);
endinterface

// ===== sv/linear_scan_register_allocator.sv =====
// Linear scan register allocator: slot chain, scan control and result register.
//
// Usage: live intervals arrive on the items channel in order of definition, one
// word each, and every interval yields exactly one word on the results channel.
// A word is moved at a rising clock edge with valid and ready both high.
// cfg_we/cfg_wdata set the physical register count; the last register is the
// spill scratch. Write it only while no interval is in flight.
// Each interval launches a token that walks the chain of MAX_REGS slot cells,
// one cell per cycle; the next interval can be accepted only once the token
// has left the chain and its result has been moved to the output register.
// The result word is registered from the token captured at the chain end. If the
// receiver stalls, the result waits in the output register; the following
// interval is accepted and scanned, and its result waits until that register
// is free, which also delays its table update.
// Reset empties every slot and sets the register count to 16.
module linear_scan_register_allocator #(
	parameter int MAX_REGS = 32,
	parameter int ID_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lsra_pkg::CFG_W-1:0]  cfg_wdata,
	lsra_item_if.sink                   items,
	lsra_result_if.source               results
);

	localparam int IDX_W   = $clog2(MAX_REGS);
	localparam int POINT_W = lsra_pkg::POINT_W;
	localparam int ID_W    = lsra_pkg::ID_W;
	localparam int REG_W   = lsra_pkg::REG_W;
	localparam int CFG_W   = lsra_pkg::CFG_W;

	typedef struct packed {
		logic               active;
		logic               found;
		logic [IDX_W-1:0]   idx;
		logic               have_best;
		logic [POINT_W-1:0] best_end;
		logic [IDX_W-1:0]   best_idx;
		logic [ID_BITS-1:0] best_owner;
	} token_t;

	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   idx;
		logic [ID_BITS-1:0] owner;
		logic [POINT_W-1:0] last;
	} slot_wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic               launch_q;
	logic [CFG_W-1:0]   num_regs_q;
	logic [ID_BITS-1:0] id_q;
	logic [POINT_W-1:0] def_q;
	logic [POINT_W-1:0] lu_q;
	token_t             fin_q;

	logic               out_valid_q;
	logic [REG_W-1:0]   out_reg_q;
	logic               out_spill_q;
	logic               out_evict_q;
	logic [ID_W-1:0]    out_evict_id_q;

	token_t             tok [MAX_REGS+1];
	logic [MAX_REGS:0]  act_vec;
	slot_wr_t           wr;
	logic               accept;
	logic               clear_all;
	logic               out_free;
	logic [IDX_W-1:0]   usable;
	logic [CFG_W:0]     num_ext;

	logic [REG_W-1:0]   dec_reg;
	logic               dec_spill;
	logic               dec_evict;
	logic [ID_W-1:0]    dec_evict_id;
	logic               dec_write;
	logic [IDX_W-1:0]   dec_idx;

	assign accept    = items.valid && items.ready;
	assign clear_all = accept && items.start_function;
	assign out_free  = !out_valid_q || results.ready;

	assign items.ready          = (state_q == ST_IDLE);
	assign results.valid        = out_valid_q;
	assign results.assigned_reg = out_reg_q;
	assign results.is_spilled   = out_spill_q;
	assign results.evicted      = out_evict_q;
	assign results.evicted_id   = out_evict_id_q;

	// Usable slots: count clamped to 1..MAX_REGS, minus the scratch register.
	assign num_ext = {1'b0, num_regs_q};
	always_comb begin
		if (num_regs_q == '0) begin
			usable = '0;
		end else if (num_ext >= (CFG_W+1)'(MAX_REGS)) begin
			usable = IDX_W'(MAX_REGS - 1);
		end else begin
			usable = IDX_W'(num_regs_q - CFG_W'(1));
		end
	end

	always_comb begin
		tok[0]        = '0;
		tok[0].active = launch_q;
	end

	genvar g;
	generate
		for (g = 0; g < MAX_REGS; g++) begin : g_cell
			lsra_cell #(
				.MAX_REGS (MAX_REGS),
				.ID_BITS  (ID_BITS),
				.INDEX    (g)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.tok_in    (tok[g]),
				.tok_out   (tok[g+1]),
				.wr_in     (wr),
				.clear_all (clear_all),
				.def_point (def_q),
				.usable    (usable)
			);
		end
		for (g = 0; g <= MAX_REGS; g++) begin : g_act
			assign act_vec[g] = tok[g].active;
		end
	endgenerate

	// Outcome of a finished scan: free slot, self spill, or eviction of the latest end.
	always_comb begin
		dec_reg      = '0;
		dec_spill    = 1'b0;
		dec_evict    = 1'b0;
		dec_evict_id = '0;
		dec_write    = 1'b0;
		dec_idx      = fin_q.idx;
		if (fin_q.found) begin
			dec_reg   = REG_W'(fin_q.idx);
			dec_write = 1'b1;
		end else if (usable == '0) begin
			dec_spill = 1'b1;
		end else if (fin_q.best_end < lu_q) begin
			dec_reg   = REG_W'(usable);
			dec_spill = 1'b1;
		end else begin
			dec_reg      = REG_W'(fin_q.best_idx);
			dec_evict    = 1'b1;
			dec_evict_id = ID_W'(fin_q.best_owner);
			dec_write    = 1'b1;
			dec_idx      = fin_q.best_idx;
		end
	end

	always_comb begin
		wr.en    = (state_q == ST_DONE) && out_free && dec_write;
		wr.idx   = dec_idx;
		wr.owner = id_q;
		wr.last  = lu_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			launch_q       <= 1'b0;
			out_valid_q    <= 1'b0;
			num_regs_q     <= lsra_pkg::NUM_REGS_RESET;
			id_q           <= '0;
			def_q          <= '0;
			lu_q           <= '0;
			fin_q          <= '0;
			out_reg_q      <= '0;
			out_spill_q    <= 1'b0;
			out_evict_q    <= 1'b0;
			out_evict_id_q <= '0;
		end else begin
			launch_q <= accept;
			if (cfg_we) begin
				num_regs_q <= cfg_wdata;
			end
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						id_q    <= ID_BITS'(items.vreg_id);
						def_q   <= items.def_point;
						lu_q    <= items.end_point;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tok[MAX_REGS].active) begin
						fin_q   <= tok[MAX_REGS];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_reg_q      <= dec_reg;
						out_spill_q    <= dec_spill;
						out_evict_q    <= dec_evict;
						out_evict_id_q <= dec_evict_id;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// At most one scan token is in the chain at any time.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(act_vec))
		else $error("more than one scan token in the slot chain");

	// A token leaving the chain is only expected while scanning.
	a_token_exit: assert property (@(posedge clk) disable iff (!arst_n)
		tok[MAX_REGS].active |-> (state_q == ST_SCAN))
		else $error("scan token left the chain outside of a scan");

	// Table writes only target usable slots.
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (wr.idx < usable))
		else $error("slot write beyond the usable registers");

	// A new word is only taken with the chain empty.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		items.ready |-> (act_vec == '0))
		else $error("input ready while a scan is in progress");

endmodule

// ===== sv/lsra_cell.sv =====
// One physical register slot of the allocator chain: holds an occupant and updates the scan token.
module lsra_cell #(
	parameter int MAX_REGS = 32,
	parameter int ID_BITS  = 16,
	parameter int INDEX    = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [2 + 2*$clog2(MAX_REGS) + 1 + lsra_pkg::POINT_W + ID_BITS - 1:0] tok_in,
	output logic [2 + 2*$clog2(MAX_REGS) + 1 + lsra_pkg::POINT_W + ID_BITS - 1:0] tok_out,
	input  logic [1 + $clog2(MAX_REGS) + ID_BITS + lsra_pkg::POINT_W - 1:0]       wr_in,
	input  logic                                                                  clear_all,
	input  logic [lsra_pkg::POINT_W-1:0]                                          def_point,
	input  logic [$clog2(MAX_REGS)-1:0]                                           usable
);

	localparam int IDX_W   = $clog2(MAX_REGS);
	localparam int POINT_W = lsra_pkg::POINT_W;
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	typedef struct packed {
		logic               active;
		logic               found;
		logic [IDX_W-1:0]   idx;
		logic               have_best;
		logic [POINT_W-1:0] best_end;
		logic [IDX_W-1:0]   best_idx;
		logic [ID_BITS-1:0] best_owner;
	} token_t;

	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   idx;
		logic [ID_BITS-1:0] owner;
		logic [POINT_W-1:0] last;
	} slot_wr_t;

	token_t   tok_cur;
	token_t   tok_nxt;
	token_t   tok_q;
	slot_wr_t wr;

	logic               valid_q;
	logic [ID_BITS-1:0] owner_q;
	logic [POINT_W-1:0] end_q;
	logic               in_range;
	logic               wr_hit;

	assign tok_cur  = tok_in;
	assign wr       = wr_in;
	assign tok_out  = tok_q;
	assign in_range = (MY_IDX < usable);
	assign wr_hit   = wr.en && (wr.idx == MY_IDX);

	// The first free slot wins; until one is found, track the latest-ending occupant.
	always_comb begin
		tok_nxt = tok_cur;
		if (tok_cur.active && in_range && !tok_cur.found) begin
			if (!valid_q || end_q <= def_point) begin
				tok_nxt.found = 1'b1;
				tok_nxt.idx   = MY_IDX;
			end else if (!tok_cur.have_best || tok_cur.best_end < end_q) begin
				tok_nxt.have_best  = 1'b1;
				tok_nxt.best_end   = end_q;
				tok_nxt.best_idx   = MY_IDX;
				tok_nxt.best_owner = owner_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			tok_q <= tok_nxt;
			if (clear_all) begin
				valid_q <= 1'b0;
			end else if (wr_hit) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			owner_q <= wr.owner;
			end_q   <= wr.last;
		end
	end

endmodule
